// File: design/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

`endif

// File: design/ssk_pkg.sv
// ----------------------------------------------------------------------------
// ssk_pkg
// Shared constants, payload types, state encoding and controller links for
// the exhaustive subset knapsack search block.
// ----------------------------------------------------------------------------
package ssk_pkg;

  // store depth and derived widths
  localparam int MAX_ITEMS = 10;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  // field widths
  localparam int VAL_W    = 16;
  localparam int SUM_W    = 20;
  localparam int CHOICE_W = 10;

  // configuration port
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int REG_IDX_W = CFG_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = REG_IDX_W'(0);

  typedef struct packed {
    logic [VAL_W-1:0] item_value;
    logic [VAL_W-1:0] item_weight;
    logic             last_item;
  } item_t;

  typedef struct packed {
    logic [SUM_W-1:0]    best_value;
    logic [SUM_W-1:0]    best_weight;
    logic [CHOICE_W-1:0] chosen_mask;
    logic                items_dropped;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_SEARCH,
    S_FLUSH,
    S_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic init;
    logic step;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic step_last;
  } dp_stat_t;

endpackage

// File: design/ssk_cfg.sv
// ----------------------------------------------------------------------------
// ssk_cfg
// APB register file holding the knapsack capacity.
// ----------------------------------------------------------------------------
module ssk_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ssk_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [ssk_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [ssk_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready,
  output logic [ssk_pkg::SUM_W-1:0]   capacity
);

  logic [ssk_pkg::SUM_W-1:0]     capacity_r;
  logic [ssk_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign reg_idx = cfg_paddr[ssk_pkg::CFG_AW-1:2];
  assign wr_en   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // capacity register; writes to other addresses are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= '0;
    end else if (wr_en && reg_idx == ssk_pkg::REG_CAPACITY) begin
      capacity_r <= cfg_pwdata[ssk_pkg::SUM_W-1:0];
    end
  end

  // read mux
  always_comb begin
    cfg_prdata = '0;
    unique case (reg_idx)
      ssk_pkg::REG_CAPACITY: cfg_prdata = ssk_pkg::CFG_DW'(capacity_r);
      default:               cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;
  assign capacity   = capacity_r;

endmodule

// File: design/ssk_ctrl.sv
// ----------------------------------------------------------------------------
// ssk_ctrl
// Sequencer: loads items, then runs the subset walk, flush and result issue.
// ----------------------------------------------------------------------------
module ssk_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               last_item,
  input  ssk_pkg::dp_stat_t  stat,
  output ssk_pkg::ctrl_cmd_t cmd,
  output logic               busy
);

  ssk_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssk_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ssk_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (last_item) begin
            state_nxt = ssk_pkg::S_INIT;
          end
        end
      end
      ssk_pkg::S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = stat.empty ? ssk_pkg::S_EMIT : ssk_pkg::S_SEARCH;
      end
      ssk_pkg::S_SEARCH: begin
        cmd.step = 1'b1;
        if (stat.step_last) begin
          state_nxt = ssk_pkg::S_FLUSH;
        end
      end
      // last candidate is compared here
      ssk_pkg::S_FLUSH: begin
        state_nxt = ssk_pkg::S_EMIT;
      end
      ssk_pkg::S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ssk_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ssk_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: design/ssk_dp.sv
// ----------------------------------------------------------------------------
// ssk_dp
// Item store, Gray-order subset accumulator, best-subset tracker and result
// register.
// ----------------------------------------------------------------------------
module ssk_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ssk_pkg::ctrl_cmd_t         cmd,
  output ssk_pkg::dp_stat_t          stat,
  input  ssk_pkg::item_t             in_item,
  input  logic [ssk_pkg::SUM_W-1:0]  capacity,
  output logic                       out_valid,
  output ssk_pkg::result_t           out_result
);

  localparam int N = ssk_pkg::MAX_ITEMS;

  // item store
  logic [ssk_pkg::VAL_W-1:0] val_mem_r [N];
  logic [ssk_pkg::VAL_W-1:0] wgt_mem_r [N];
  logic [ssk_pkg::CNT_W-1:0] items_held_r;
  logic                      overflow_r;
  logic                      has_room;

  // walk state
  logic [N-1:0]              k_r;
  logic [N-1:0]              gray_r;
  logic [ssk_pkg::SUM_W-1:0] sum_v_r, sum_w_r;
  logic                      cand_vld_r;
  logic [ssk_pkg::IDX_W-1:0] flip_idx;
  logic [ssk_pkg::VAL_W-1:0] flip_val, flip_wgt;
  logic                      flip_out;
  logic [N:0]                lim;

  // best so far
  logic [ssk_pkg::SUM_W-1:0] best_v_r, best_w_r;
  logic [N-1:0]              best_mask_r;
  logic                      fits, better;

  ssk_pkg::result_t out_result_r;
  logic             out_valid_r;

  assign has_room = items_held_r < ssk_pkg::CNT_W'(N);

  // item writes
  always_ff @(posedge clk) begin
    if (cmd.load && has_room) begin
      val_mem_r[items_held_r[ssk_pkg::IDX_W-1:0]] <= in_item.item_value;
      wgt_mem_r[items_held_r[ssk_pkg::IDX_W-1:0]] <= in_item.item_weight;
    end
  end

  // fill count and overflow flag, cleared once the result goes out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      items_held_r <= '0;
      overflow_r   <= 1'b0;
    end else if (cmd.emit) begin
      items_held_r <= '0;
      overflow_r   <= 1'b0;
    end else if (cmd.load) begin
      if (has_room) begin
        items_held_r <= items_held_r + ssk_pkg::CNT_W'(1);
      end else begin
        overflow_r <= 1'b1;
      end
    end
  end

  // lowest set bit of the step count picks the item that toggles
  always_comb begin
    flip_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (k_r[i]) begin
        flip_idx = ssk_pkg::IDX_W'(i);
      end
    end
  end

  assign flip_val = val_mem_r[flip_idx];
  assign flip_wgt = wgt_mem_r[flip_idx];
  assign flip_out = gray_r[flip_idx];

  // status: last step when k reaches 2^n - 1
  assign lim            = (N + 1)'(1) << items_held_r;
  assign stat.step_last = ({1'b0, k_r} == lim - (N + 1)'(1));
  assign stat.empty     = (items_held_r == '0);

  // one subset per cycle: add or remove a single item
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      k_r     <= N'(1);
      gray_r  <= '0;
      sum_v_r <= '0;
      sum_w_r <= '0;
    end else if (cmd.step) begin
      k_r    <= k_r + N'(1);
      gray_r <= gray_r ^ (N'(1) << flip_idx);
      if (flip_out) begin
        sum_v_r <= sum_v_r - ssk_pkg::SUM_W'(flip_val);
        sum_w_r <= sum_w_r - ssk_pkg::SUM_W'(flip_wgt);
      end else begin
        sum_v_r <= sum_v_r + ssk_pkg::SUM_W'(flip_val);
        sum_w_r <= sum_w_r + ssk_pkg::SUM_W'(flip_wgt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_vld_r <= 1'b0;
    end else begin
      cand_vld_r <= cmd.step;
    end
  end

  // walk order is not ascending, so ties go to the lower mask
  assign fits   = (sum_w_r <= capacity);
  assign better = (sum_v_r > best_v_r) ||
                  ((sum_v_r == best_v_r) && (gray_r < best_mask_r));

  // empty subset always fits and seeds the best
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      best_v_r    <= '0;
      best_w_r    <= '0;
      best_mask_r <= '0;
    end else if (cand_vld_r && fits && better) begin
      best_v_r    <= sum_v_r;
      best_w_r    <= sum_w_r;
      best_mask_r <= gray_r;
    end
  end

  // result register, strobed for one cycle
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_result_r.best_value    <= best_v_r;
      out_result_r.best_weight   <= best_w_r;
      out_result_r.chosen_mask   <= ssk_pkg::CHOICE_W'(best_mask_r);
      out_result_r.items_dropped <= overflow_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

// File: design/subset_knapsack_search_top.sv
// ----------------------------------------------------------------------------
// subset_knapsack_search_top
// Exhaustive 0/1 knapsack search over a small store of items.
// ----------------------------------------------------------------------------
// Items are taken one per cycle while busy is low (start high transfers one);
// up to MAX_ITEMS (10) are kept and further ones are dropped and flagged.
// The transfer marked last_item raises busy and starts the search, which walks
// all 2^n subsets of the n stored items in Gray-code order through one
// add/subtract pair and one compare, one subset per cycle. The single result
// appears on out_result with out_valid high for exactly one cycle; it cannot
// be stalled and must be taken in that cycle. busy drops in the same cycle,
// and the store is empty again for the next set. Capacity is set over the APB
// port, by the user only while the block is idle; the block itself does not
// enforce this.
module subset_knapsack_search_top (
  input  logic                       clk,
  input  logic                       rst_n,
  // item channel
  input  logic                       start,
  output logic                       busy,
  input  ssk_pkg::item_t             in_item,
  // result channel
  output logic                       out_valid,
  output ssk_pkg::result_t           out_result,
  // configuration
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ssk_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [ssk_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [ssk_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  ssk_pkg::ctrl_cmd_t        cmd;
  ssk_pkg::dp_stat_t         stat;
  logic [ssk_pkg::SUM_W-1:0] capacity;

  ssk_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .capacity    (capacity)
  );

  ssk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .last_item (in_item.last_item),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  ssk_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_item    (in_item),
    .capacity   (capacity),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

// File: design/ssk_checker.sv
// ----------------------------------------------------------------------------
// ssk_checker
// Port-level checks on the search sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssk_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input ssk_pkg::item_t   in_item,
  input logic             out_valid
);

  logic acc_last, acc_more;

  assign acc_last = start && !busy && in_item.last_item;
  assign acc_more = start && !busy && !in_item.last_item;

  // last item starts the search
  `ASSERT_NEXT(a_last_goes_busy, clk, rst_n, acc_last, busy, "search did not start")
  // a plain item neither blocks nor produces a result
  `ASSERT_NEXT(a_load_stays_idle, clk, rst_n, acc_more, !busy && !out_valid, "bad load")
  // result is a single-cycle strobe
  `ASSERT_NEXT(a_strobe_one_cycle, clk, rst_n, out_valid, !out_valid, "strobe too long")
  // result only leaves once the search has finished
  `ASSERT_SAME(a_result_when_idle, clk, rst_n, out_valid, !busy, "result while busy")

endmodule

bind subset_knapsack_search_top ssk_checker u_ssk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid)
);

// File: bench/subset_knapsack_search_top_test.sv
// ----------------------------------------------------------------------------
// subset_knapsack_search_top_test
// Self-checking bench for the exhaustive subset knapsack search block.
// ----------------------------------------------------------------------------
// Item sets are sent through the start/busy port. A scoreboard keeps its own
// copy of the item store and the capacity and, on every transfer marked
// last_item, works out the best fitting subset and queues it. Each strobed
// result is checked field by field against the oldest queued one. Capacity
// is written and read back over APB while the block is idle, between phases.
// A directed part covers the field extremes, store overflow, sets where
// nothing fits and value ties; random phases follow with mostly small sets.
// ----------------------------------------------------------------------------
module subset_knapsack_search_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ssk_pkg::*;

  localparam int N_ITEMS = 2000;
  localparam logic [CFG_AW-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

  // Scoreboard: item store copy, capacity copy and queue of best fits
  class knapsack_scoreboard;
    logic [VAL_W-1:0] vals[MAX_ITEMS];
    logic [VAL_W-1:0] wts[MAX_ITEMS];
    int               held;
    logic             dropped;
    logic [SUM_W-1:0] cap;
    result_t          best_fits[$];
    int               errors;

    function new();
      held    = 0;
      dropped = 1'b0;
      cap     = '0;
      errors  = 0;
    endfunction

    function void set_capacity(logic [SUM_W-1:0] c);
      cap = c;
    endfunction

    function int pending();
      return best_fits.size();
    endfunction

    function void fail(string msg);
      errors++;
      $error("%s", msg);
    endfunction

    // walk every subset in mask order; lowest mask wins a tie
    function void search();
      result_t          r;
      logic [SUM_W-1:0] sv;
      logic [SUM_W-1:0] sw;
      r = '0;
      for (int m = 0; m < (1 << held); m++) begin
        sv = '0;
        sw = '0;
        for (int k = 0; k < held; k++) begin
          if (m[k]) begin
            sv += SUM_W'(vals[k]);
            sw += SUM_W'(wts[k]);
          end
        end
        if (sw <= cap && (m == 0 || sv > r.best_value)) begin
          r.best_value  = sv;
          r.best_weight = sw;
          r.chosen_mask = CHOICE_W'(m);
        end
      end
      r.items_dropped = dropped;
      best_fits.push_back(r);
    endfunction

    // accepted item transfer
    function void note_item(item_t it);
      if (held < MAX_ITEMS) begin
        vals[held] = it.item_value;
        wts[held]  = it.item_weight;
        held++;
      end else begin
        dropped = 1'b1;
      end
      if (it.last_item) begin
        search();
        held    = 0;
        dropped = 1'b0;
      end
    endfunction

    function void field_check(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v !== got_v)
        fail($sformatf("%s: expected %0d, got %0d", name, exp_v, got_v));
    endfunction

    // accepted result transfer
    function void check_result(result_t got);
      result_t exp_r;
      if (best_fits.size() == 0) begin
        fail("result with no search pending");
        return;
      end
      exp_r = best_fits.pop_front();
      field_check("best_value", exp_r.best_value, got.best_value);
      field_check("best_weight", exp_r.best_weight, got.best_weight);
      field_check("chosen_mask", exp_r.chosen_mask, got.chosen_mask);
      field_check("items_dropped", exp_r.items_dropped, got.items_dropped);
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  item_t             in_item;
  logic              out_valid;
  result_t           out_result;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  knapsack_scoreboard sb;
  bit                 no_idle;
  int                 items_done;

  subset_knapsack_search_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_result  (out_result),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result monitor: one transfer per strobed cycle
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_result);
  end

  // sender gap: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one item transfer, then an optional gap
  task automatic send(input logic [VAL_W-1:0] v, input logic [VAL_W-1:0] w,
                      input logic last);
    item_t it;
    int    g;
    it.item_value  = v;
    it.item_weight = w;
    it.last_item   = last;
    in_item <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_item(it);
    g = pick_gap();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // stop sending and wait until every search has reported
  task automatic drain(input int extra);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // APB write of capacity, then read back
  task automatic set_capacity(input logic [SUM_W-1:0] c);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CAP_ADDR;
    cfg_pwdata  <= CFG_DW'(c);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_capacity(c);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== CFG_DW'(c))
      sb.fail($sformatf("capacity readback: expected %0d, got %0d", c, cfg_prdata));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [SUM_W-1:0] pick_capacity();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return SUM_W'($urandom_range(0, 200));
      3: return SUM_W'($urandom_range(0, 150000));
      4: return SUM_W'($urandom_range(0, 65535));
      default: return SUM_W'($urandom);
    endcase
  endfunction

  // random set: mostly small, some full, a few overflowing the store
  task automatic send_random_set();
    int               size;
    int               r;
    bit               small_vals;
    bit               small_wts;
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] w;
    r = $urandom_range(0, 99);
    if (r < 55) size = $urandom_range(1, 4);
    else if (r < 80) size = $urandom_range(5, 8);
    else if (r < 93) size = $urandom_range(9, MAX_ITEMS);
    else size = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
    small_vals = $urandom_range(0, 2) == 0;
    small_wts  = $urandom_range(0, 2) == 0;
    for (int i = 0; i < size; i++) begin
      v = small_vals ? VAL_W'($urandom_range(0, 7)) : VAL_W'($urandom);
      w = small_wts ? VAL_W'($urandom_range(0, 63)) : VAL_W'($urandom);
      send(v, w, i == size - 1);
      if (i < MAX_ITEMS) items_done++;
    end
  endtask

  // main sequence
  initial begin
    int n_sets;
    sb          = new();
    items_done  = 0;
    no_idle     = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero capacity: a weightless item fits, a heavy one does not
    set_capacity('0);
    send('1, '0, 1'b1);
    send(16'd5, 16'd1, 1'b1);
    drain(8);

    // full capacity: store overflow, last item dropped, all extremes
    set_capacity('1);
    for (int i = 0; i < MAX_ITEMS + 1; i++) send('1, '1, i == MAX_ITEMS);
    drain(8);

    // ties between equal values, an unfit item, a zero item
    set_capacity(SUM_W'(100));
    send(16'd7, 16'd50, 1'b0);
    send(16'd7, 16'd60, 1'b0);
    send(16'd7, 16'd100, 1'b1);
    send(16'd0, 16'd0, 1'b0);
    send(16'd1, 16'd101, 1'b1);
    send(16'h8000, 16'd100, 1'b0);
    send(16'h7fff, 16'd0, 1'b1);
    drain(8);

    // random phases
    while (items_done < N_ITEMS) begin
      set_capacity(pick_capacity());
      no_idle = $urandom_range(0, 3) == 0;
      n_sets  = $urandom_range(4, 24);
      for (int s = 0; s < n_sets; s++) send_random_set();
      drain(8);
    end

    drain(1100);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("subset_knapsack_search_top_test passed");
    else
      $display("subset_knapsack_search_top_test failed");
    $finish;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("subset_knapsack_search_top_test failed");
    $finish;
  end

endmodule
